FILE: hw/rtl/apg_pkg.sv
// Shared types and constants for the 2x2 stride-2 average pooling block.
// No dependencies; used by apg_cfg, apg_ctrl and avg_pool_2x2_stride2.
package apg_pkg;

    localparam int CFG_W      = 11;    // width of each configuration register
    localparam int CFG_ADDR_W = 4;     // byte address, registers at 4*i
    localparam int ROW_W      = 10;    // row counter, up to 1024 rows
    localparam int CHAN_W     = 10;    // channel counter, up to 1024 channels
    localparam int MAX_ROWS   = 1024;
    localparam int MAX_CHANS  = 1024;

    typedef enum logic [1:0] {
        REG_WIDTH,
        REG_HEIGHT,
        REG_CHANNELS
    } t_reg_idx;

    typedef struct packed {
        logic [CFG_W-1:0] width;
        logic [CFG_W-1:0] height;
        logic [CFG_W-1:0] channels;
    } t_cfg;

    // position of the pixel now at the input
    typedef struct packed {
        logic col_odd;
        logic row_odd;
        logic fin;       // closes the final window of the tensor
    } t_pos;

endpackage

FILE: hw/rtl/apg_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module apg_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 512,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/apg_cfg.sv
// APB register file: width, height and channel count of the tensor.
// Depends on apg_pkg.
module apg_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [apg_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    output apg_pkg::t_cfg                  o_cfg
);
    import apg_pkg::*;

    logic [CFG_W-1:0] r_width;
    logic [CFG_W-1:0] r_height;
    logic [CFG_W-1:0] r_channels;
    logic             wr;
    t_reg_idx         sel;

    assign pready = 1'b1;
    assign wr     = psel & penable & pwrite;
    assign sel    = t_reg_idx'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width    <= CFG_W'(4);
            r_height   <= CFG_W'(4);
            r_channels <= CFG_W'(1);
        end else if (wr) begin
            case (sel)
                REG_WIDTH:    r_width    <= pwdata[CFG_W-1:0];
                REG_HEIGHT:   r_height   <= pwdata[CFG_W-1:0];
                REG_CHANNELS: r_channels <= pwdata[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (sel)
            REG_WIDTH:    prdata = 32'(r_width);
            REG_HEIGHT:   prdata = 32'(r_height);
            REG_CHANNELS: prdata = 32'(r_channels);
            default:      prdata = 32'd0;
        endcase
    end

    assign o_cfg = '{width: r_width, height: r_height, channels: r_channels};

endmodule

FILE: hw/rtl/apg_ctrl.sv
// Raster position counters (column, row, channel), register clamping,
// line store index and final-window flag. Depends on apg_pkg.
module apg_ctrl #(
    parameter int MAX_WIDTH = 1024,
    localparam int COL_W    = $clog2(MAX_WIDTH),
    localparam int DEPTH    = MAX_WIDTH / 2,
    localparam int AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  apg_pkg::t_cfg i_cfg,
    input  logic          i_step,
    output apg_pkg::t_pos o_pos,
    output logic [AW-1:0] o_idx
);
    import apg_pkg::*;

    localparam int WB = $clog2(MAX_WIDTH + 1);
    localparam int WW = (WB > CFG_W) ? WB : CFG_W;

    logic [COL_W-1:0]  r_col;
    logic [ROW_W-1:0]  r_row;
    logic [CHAN_W-1:0] r_chan;
    logic [COL_W-1:0]  n_col;
    logic [ROW_W-1:0]  n_row;
    logic [CHAN_W-1:0] n_chan;

    logic [WW-1:0]    w_raw, w_eff, col_nx;
    logic [CFG_W-1:0] h_eff, c_eff, row_nx, chan_nx;
    logic             col_wrap, row_wrap, chan_wrap;
    logic [COL_W-1:0] half, half_adj;

    // clamp registers into their legal ranges
    always_comb begin
        w_raw = WW'(i_cfg.width);
        if (w_raw < WW'(2)) begin
            w_eff = WW'(2);
        end else if (w_raw > WW'(MAX_WIDTH)) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = w_raw;
        end
        if (i_cfg.height < CFG_W'(2)) begin
            h_eff = CFG_W'(2);
        end else if (i_cfg.height > CFG_W'(MAX_ROWS)) begin
            h_eff = CFG_W'(MAX_ROWS);
        end else begin
            h_eff = i_cfg.height;
        end
        if (i_cfg.channels < CFG_W'(1)) begin
            c_eff = CFG_W'(1);
        end else if (i_cfg.channels > CFG_W'(MAX_CHANS)) begin
            c_eff = CFG_W'(MAX_CHANS);
        end else begin
            c_eff = i_cfg.channels;
        end
    end

    assign col_nx    = WW'(r_col) + WW'(1);
    assign row_nx    = CFG_W'(r_row) + CFG_W'(1);
    assign chan_nx   = CFG_W'(r_chan) + CFG_W'(1);
    assign col_wrap  = col_nx >= w_eff;
    assign row_wrap  = row_nx >= h_eff;
    assign chan_wrap = chan_nx >= c_eff;

    always_comb begin
        n_col  = r_col;
        n_row  = r_row;
        n_chan = r_chan;
        if (i_step) begin
            if (col_wrap) begin
                n_col = '0;
                if (row_wrap) begin
                    n_row  = '0;
                    n_chan = chan_wrap ? '0 : chan_nx[CHAN_W-1:0];
                end else begin
                    n_row = row_nx[ROW_W-1:0];
                end
            end else begin
                n_col = col_nx[COL_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_chan <= '0;
        end else begin
            r_col  <= n_col;
            r_row  <= n_row;
            r_chan <= n_chan;
        end
    end

    // one entry per column pair; folds back once for an odd maximum width
    assign half     = r_col >> 1;
    assign half_adj = (half >= COL_W'(DEPTH)) ? half - COL_W'(DEPTH) : half;
    assign o_idx    = half_adj[AW-1:0];

    assign o_pos.col_odd = r_col[0];
    assign o_pos.row_odd = r_row[0];
    assign o_pos.fin     = (CFG_W'(r_chan) == c_eff - CFG_W'(1)) &&
                           (CFG_W'(r_row) == {h_eff[CFG_W-1:1], 1'b0} - CFG_W'(1)) &&
                           (WW'(r_col) == {w_eff[WW-1:1], 1'b0} - WW'(1));

endmodule

FILE: hw/rtl/avg_pool_2x2_stride2.sv
// 2x2 average pooling, stride 2, over a streamed feature map.
//
// Pixels enter on the s_axis channel one per request, in channel, row, column
// raster order. Each non-overlapping 2x2 window aligned to even rows and
// columns yields one request on m_axis: the exact sum of the four samples,
// read as the average with two extra fraction bits. tlast marks the final
// window of the tensor. A trailing odd column or row produces nothing.
// Row width, height and channel count are set through the APB port and must
// only change while the block is idle.
//
// Throughput: one pixel per clock while the receiver does not stall. The column
// pair sum is added at the input, the even-row pair sums sit in a line store of
// MAX_WIDTH/2 entries with a registered read, and the window sum is formed in
// the cycle after that read. A window passes through the middle stage and then
// the output register before it is offered on m_axis.
// Reset clears the counters and the pipeline valids; the line store is not
// cleared, since every entry is written on an even row before it is read.
// When the receiver stalls, the result waits in the output register, one more
// window may wait in the stage before it, and s_axis then drops tready.
// Depends on apg_pkg, apg_cfg, apg_ctrl and apg_ram.
module avg_pool_2x2_stride2 #(
    parameter int MAX_WIDTH  = 1024,
    parameter int PIXEL_BITS = 16,
    localparam int IN_W      = ((PIXEL_BITS + 7) / 8) * 8,
    localparam int OUT_W     = ((PIXEL_BITS + 2 + 7) / 8) * 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // pixel stream
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [IN_W-1:0]                s_axis_tdata,   // [PIXEL_BITS-1:0] pixel
    // pooled stream
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [OUT_W-1:0]               m_axis_tdata,   // [PIXEL_BITS+1:0] average
    output logic                           m_axis_tlast,
    // configuration
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [apg_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);
    import apg_pkg::*;

    localparam int SW    = PIXEL_BITS + 1;
    localparam int OB    = PIXEL_BITS + 2;
    localparam int DEPTH = MAX_WIDTH / 2;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_cfg          cfg;
    t_pos          pos;
    logic [AW-1:0] idx;

    logic          accept, emit, out_free;
    logic          ram_we, ram_re;
    logic [SW-1:0] px_ext, pair_total, ram_rdata;
    logic [OB-1:0] window_sum;

    logic [SW-1:0] r_pair;
    logic          r_s1_valid;
    logic [SW-1:0] r_s1_sum;
    logic          r_s1_last;
    logic          r_out_valid;
    logic [OB-1:0] r_out_avg;
    logic          r_out_last;

    apg_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    apg_ctrl #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_step  (accept),
        .o_pos   (pos),
        .o_idx   (idx)
    );

    apg_ram #(
        .WIDTH (SW),
        .DEPTH (DEPTH)
    ) u_line (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (idx),
        .i_wdata (pair_total),
        .i_re    (ram_re),
        .i_raddr (idx),
        .o_rdata (ram_rdata)
    );

    assign out_free      = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_s1_valid || out_free;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign emit          = pos.col_odd && pos.row_odd;

    assign px_ext     = {s_axis_tdata[PIXEL_BITS-1], s_axis_tdata[PIXEL_BITS-1:0]};
    assign pair_total = r_pair + px_ext;
    assign ram_we     = accept && pos.col_odd && !pos.row_odd;
    assign ram_re     = accept && emit;
    assign window_sum = {ram_rdata[SW-1], ram_rdata} + {r_s1_sum[SW-1], r_s1_sum};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pair      <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept && !pos.col_odd) begin
                r_pair <= px_ext;
            end
            if (s_axis_tready) begin
                r_s1_valid <= accept && emit;
            end
            if (out_free) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept && emit) begin
            r_s1_sum  <= pair_total;
            r_s1_last <= pos.fin;
        end
        if (out_free && r_s1_valid) begin
            r_out_avg  <= window_sum;
            r_out_last <= r_s1_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_W'(r_out_avg);
    assign m_axis_tlast  = r_out_last;

    // a window held in the middle stage keeps its partial sum until it moves on
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !out_free) |=> (r_s1_valid && $stable(r_s1_sum)))
        else $error("middle stage lost or changed a held window");

    // the line store is never written and read for the same pixel
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(ram_we && ram_re))
        else $error("line store written and read together");

    // a pixel closing a window always reaches the middle stage
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && emit) |=> r_s1_valid)
        else $error("window-closing pixel dropped");

    // a middle stage that can move on always fills the output register
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && out_free) |=> r_out_valid)
        else $error("window lost between middle stage and output");

endmodule
